### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Each use expects clk_i, and
// DTSV_ASSERT also rst_ni, in scope of the including module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset
`define DTSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising edge, reset included
`define DTSV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/dtsv_pkg.sv
// ----------------------------------------------------------------------------
// dtsv_pkg
// Types and constants shared by the date-time string validator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtsv_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [13:0] ValMax    = 14'd9999;
  localparam logic [13:0] MonthMax  = 14'd12;
  localparam logic [13:0] HourMax   = 14'd23;
  localparam logic [13:0] MinSecMax = 14'd59;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_YEAR   = 3'd1,
    ERR_MONTH  = 3'd2,
    ERR_DAY    = 3'd3,
    ERR_HOUR   = 3'd4,
    ERR_MINUTE = 3'd5,
    ERR_SECOND = 3'd6,
    ERR_DELIM  = 3'd7
  } dtsv_err_e;

  typedef enum logic [1:0] {
    CMP_FULL   = 2'd0,
    CMP_DATE   = 2'd1,
    CMP_NO_SEC = 2'd2
  } dtsv_cmp_e;

  typedef struct packed {
    logic        valid_res;
    logic [2:0]  error_code;
    logic [1:0]  completeness;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } dtsv_result_t;

endpackage

### rtl/dtsv_parser.sv
// ----------------------------------------------------------------------------
// dtsv_parser
// Field state machine: takes one character per step, accumulates decimal
// fields, range checks them and builds the result on the terminating NUL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtsv_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             char_i,
  output logic                   emit_o,
  output dtsv_pkg::dtsv_result_t res_o
);

  typedef enum logic [2:0] {
    PH_YEAR   = 3'd0,
    PH_MONTH  = 3'd1,
    PH_DAY    = 3'd2,
    PH_HOUR   = 3'd3,
    PH_MINUTE = 3'd4,
    PH_SECOND = 3'd5
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [13:0]         acc_q, acc_d;
  logic                sat_q, sat_d;
  logic                neg_q, neg_d;
  logic                pre_q, pre_d;
  logic                dseen_q, dseen_d;
  logic                sgn_q, sgn_d;
  dtsv_pkg::dtsv_err_e err_q, err_d;
  logic [13:0]         year_q, year_d;
  logic [3:0]          month_q, month_d;
  logic [4:0]          day_q, day_d;
  logic [4:0]          hour_q, hour_d;
  logic [5:0]          minute_q, minute_d;
  logic                leap_q, leap_d;
  logic [3:0][3:0]     bcd_q, bcd_d;

  logic                is_dig, is_ws, is_sign, is_nul;
  logic [16:0]         acc_ext, acc_next;
  logic                forced, bad, range_err, leap_now, ok_delim, ends;
  logic [13:0]         fld_v;
  logic [4:0]          dim;
  dtsv_pkg::dtsv_err_e range_code, err_n;
  dtsv_pkg::dtsv_cmp_e cmp_n;
  logic [5:0]          sec_n;

  function automatic logic div4(input logic [3:0] tens, input logic [3:0] ones);
    logic [1:0] s;
    s = {tens[0], 1'b0} + ones[1:0];
    return (s == 2'b00);
  endfunction

  assign is_dig  = (char_i >= dtsv_pkg::CH_0) && (char_i <= dtsv_pkg::CH_9);
  assign is_ws   = char_i inside {[dtsv_pkg::CH_TAB:dtsv_pkg::CH_CR], dtsv_pkg::CH_SPACE};
  assign is_sign = (char_i == dtsv_pkg::CH_PLUS) || (char_i == dtsv_pkg::CH_MINUS);
  assign is_nul  = (char_i == dtsv_pkg::CH_NUL);

  assign acc_ext  = 17'(acc_q);
  assign acc_next = (acc_ext << 3) + (acc_ext << 1) + 17'(char_i[3:0]);

  assign forced = pre_q && !dseen_q;
  assign bad    = sat_q || (neg_q && (acc_q != '0));
  assign fld_v  = forced ? '0 : acc_q;

  assign leap_now = ((bcd_q[1] == 4'd0) && (bcd_q[0] == 4'd0)) ?
                    div4(bcd_q[3], bcd_q[2]) : div4(bcd_q[1], bcd_q[0]);

  always_comb begin
    if (month_q inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      dim = 5'd30;
    end else if (month_q == 4'd2) begin
      dim = leap_q ? 5'd29 : 5'd28;
    end else begin
      dim = 5'd31;
    end
  end

  always_comb begin
    case (phase_q)
      PH_YEAR: begin
        range_err  = bad || (fld_v > dtsv_pkg::ValMax);
        range_code = dtsv_pkg::ERR_YEAR;
      end
      PH_MONTH: begin
        range_err  = bad || (fld_v == '0) || (fld_v > dtsv_pkg::MonthMax);
        range_code = dtsv_pkg::ERR_MONTH;
      end
      PH_DAY: begin
        range_err  = bad || (fld_v == '0) || (fld_v > 14'(dim));
        range_code = dtsv_pkg::ERR_DAY;
      end
      PH_HOUR: begin
        range_err  = bad || (fld_v > dtsv_pkg::HourMax);
        range_code = dtsv_pkg::ERR_HOUR;
      end
      PH_MINUTE: begin
        range_err  = bad || (fld_v > dtsv_pkg::MinSecMax);
        range_code = dtsv_pkg::ERR_MINUTE;
      end
      default: begin
        range_err  = bad || (fld_v > dtsv_pkg::MinSecMax);
        range_code = dtsv_pkg::ERR_SECOND;
      end
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    sat_d    = sat_q;
    neg_d    = neg_q;
    pre_d    = pre_q;
    dseen_d  = dseen_q;
    sgn_d    = sgn_q;
    err_d    = err_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    leap_d   = leap_q;
    bcd_d    = bcd_q;
    err_n    = dtsv_pkg::ERR_NONE;
    cmp_n    = dtsv_pkg::CMP_FULL;
    sec_n    = '0;
    ok_delim = 1'b0;
    ends     = 1'b0;
    emit_o   = 1'b0;

    if (!step_i) begin
      emit_o = 1'b0;
    end else if (err_q != dtsv_pkg::ERR_NONE) begin
      if (is_nul) begin
        emit_o = 1'b1;
        err_n  = err_q;
      end
    end else if (is_dig) begin
      if (sat_q || (acc_next > 17'(dtsv_pkg::ValMax))) begin
        sat_d = 1'b1;
        acc_d = dtsv_pkg::ValMax;
      end else begin
        acc_d = acc_next[13:0];
      end
      dseen_d = 1'b1;
      bcd_d   = {bcd_q[2:0], char_i[3:0]};
    end else if (!dseen_q && !sgn_q && is_ws) begin
      pre_d = 1'b1;
    end else if (!dseen_q && !sgn_q && is_sign) begin
      sgn_d = 1'b1;
      pre_d = 1'b1;
      neg_d = (char_i == dtsv_pkg::CH_MINUS);
    end else begin
      if (range_err) begin
        err_n = range_code;
      end else if (forced) begin
        err_n = dtsv_pkg::ERR_DELIM;
      end else begin
        case (phase_q)
          PH_YEAR: begin
            year_d   = fld_v;
            leap_d   = leap_now;
            ok_delim = (char_i == dtsv_pkg::CH_MINUS);
          end
          PH_MONTH: begin
            month_d  = fld_v[3:0];
            ok_delim = (char_i == dtsv_pkg::CH_MINUS);
          end
          PH_DAY: begin
            day_d    = fld_v[4:0];
            ok_delim = (char_i == dtsv_pkg::CH_SPACE) || is_nul;
            ends     = is_nul;
            cmp_n    = dtsv_pkg::CMP_DATE;
          end
          PH_HOUR: begin
            hour_d   = fld_v[4:0];
            ok_delim = (char_i == dtsv_pkg::CH_COLON);
          end
          PH_MINUTE: begin
            minute_d = fld_v[5:0];
            ok_delim = (char_i == dtsv_pkg::CH_COLON) || is_nul;
            ends     = is_nul;
            cmp_n    = dtsv_pkg::CMP_NO_SEC;
          end
          default: begin
            ok_delim = is_nul;
            ends     = is_nul;
            cmp_n    = dtsv_pkg::CMP_FULL;
            sec_n    = fld_v[5:0];
          end
        endcase
        if (!ok_delim) begin
          err_n = dtsv_pkg::ERR_DELIM;
        end
      end

      if (err_n != dtsv_pkg::ERR_NONE) begin
        if (is_nul) begin
          emit_o = 1'b1;
        end else begin
          err_d = err_n;
        end
      end else if (ends) begin
        emit_o = 1'b1;
      end else begin
        case (phase_q)
          PH_YEAR:   phase_d = PH_MONTH;
          PH_MONTH:  phase_d = PH_DAY;
          PH_DAY:    phase_d = PH_HOUR;
          PH_HOUR:   phase_d = PH_MINUTE;
          PH_MINUTE: phase_d = PH_SECOND;
          default:   phase_d = PH_YEAR;
        endcase
        acc_d   = '0;
        sat_d   = 1'b0;
        neg_d   = 1'b0;
        pre_d   = 1'b0;
        dseen_d = 1'b0;
        sgn_d   = 1'b0;
        bcd_d   = '0;
      end
    end

    res_o.valid_res    = (err_n == dtsv_pkg::ERR_NONE);
    res_o.error_code   = err_n;
    res_o.completeness = (err_n == dtsv_pkg::ERR_NONE) ? cmp_n : dtsv_pkg::CMP_FULL;
    res_o.year         = year_d;
    res_o.month        = month_d;
    res_o.day          = day_d;
    res_o.hour         = hour_d;
    res_o.minute       = minute_d;
    res_o.second       = (err_n == dtsv_pkg::ERR_NONE) ? sec_n : '0;

    if (emit_o) begin
      phase_d  = PH_YEAR;
      acc_d    = '0;
      sat_d    = 1'b0;
      neg_d    = 1'b0;
      pre_d    = 1'b0;
      dseen_d  = 1'b0;
      sgn_d    = 1'b0;
      err_d    = dtsv_pkg::ERR_NONE;
      year_d   = '0;
      month_d  = '0;
      day_d    = '0;
      hour_d   = '0;
      minute_d = '0;
      leap_d   = 1'b0;
      bcd_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_YEAR;
      acc_q    <= '0;
      sat_q    <= 1'b0;
      neg_q    <= 1'b0;
      pre_q    <= 1'b0;
      dseen_q  <= 1'b0;
      sgn_q    <= 1'b0;
      err_q    <= dtsv_pkg::ERR_NONE;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      leap_q   <= 1'b0;
      bcd_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      sat_q    <= sat_d;
      neg_q    <= neg_d;
      pre_q    <= pre_d;
      dseen_q  <= dseen_d;
      sgn_q    <= sgn_d;
      err_q    <= err_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      leap_q   <= leap_d;
      bcd_q    <= bcd_d;
    end
  end

  `DTSV_ASSERT(a_emit_on_nul, emit_o |-> (char_i == dtsv_pkg::CH_NUL), "result without NUL")
  `DTSV_ASSERT(a_clear_after_emit, emit_o |=> (phase_q == PH_YEAR) && (err_q == dtsv_pkg::ERR_NONE) && (year_q == '0), "state not cleared after result")
  `DTSV_ASSERT(a_acc_capped, acc_q <= dtsv_pkg::ValMax, "accumulator above cap")

endmodule

### rtl/dtsv_out_reg.sv
// ----------------------------------------------------------------------------
// dtsv_out_reg
// Result register: holds one finished transaction until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtsv_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  dtsv_pkg::dtsv_result_t res_i,
  input  logic                   stall_i,
  output logic                   valid_o,
  output logic                   free_o,
  output dtsv_pkg::dtsv_result_t res_o
);

  logic                   valid_q, valid_d;
  dtsv_pkg::dtsv_result_t res_q;

  assign free_o  = !valid_q || !stall_i;
  assign valid_d = load_i || (valid_q && stall_i);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

### rtl/datetime_string_validator_unit.sv
// ----------------------------------------------------------------------------
// datetime_string_validator_unit
// Checks a YYYY-MM-DD HH:mm:ss character stream, in which the time or just the
// seconds may be left off, and reports one result per NUL-terminated string.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------
//   in      | sink      | in_valid_i/in_stall_o | char_in_i
//   out     | source    | out_valid_o/out_stall_i | valid_res_o .. second_out_o
//
// One character per cycle, sustained unless a NUL waits on a stalled result
// register; the input register and the field state update in the parser set that figure.
// A NUL waits in the input register; its result is loaded into the result register once that register is free.
// Reset clears the parser state and both valid flags.
// Only a NUL waits in the input register while the result register is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module datetime_string_validator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        valid_res_o,
  output logic [2:0]  error_code_o,
  output logic [1:0]  completeness_o,
  output logic [13:0] year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [4:0]  hour_out_o,
  output logic [5:0]  minute_out_o,
  output logic [5:0]  second_out_o
);

  logic                   s1_valid_q, s1_valid_d;
  logic [7:0]             char_q;
  logic                   s1_adv, in_acc, res_free, emit;
  dtsv_pkg::dtsv_result_t res_c, res_q;

  assign s1_adv     = s1_valid_q && ((char_q != dtsv_pkg::CH_NUL) || res_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_acc || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      char_q <= char_in_i;
    end
  end

  dtsv_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .char_i (char_q),
    .emit_o (emit),
    .res_o  (res_c)
  );

  dtsv_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit),
    .res_i   (res_c),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .free_o  (res_free),
    .res_o   (res_q)
  );

  assign valid_res_o    = res_q.valid_res;
  assign error_code_o   = res_q.error_code;
  assign completeness_o = res_q.completeness;
  assign year_out_o     = res_q.year;
  assign month_out_o    = res_q.month;
  assign day_out_o      = res_q.day;
  assign hour_out_o     = res_q.hour;
  assign minute_out_o   = res_q.minute;
  assign second_out_o   = res_q.second;

  `DTSV_ASSERT(a_char_never_stalls,
    (s1_valid_q && (char_q != dtsv_pkg::CH_NUL)) |-> !in_stall_o,
    "non-NUL transaction stalled")
  `DTSV_ASSERT(a_err_fields_zero,
    (out_valid_o && !valid_res_o) |-> ((completeness_o == 2'd0) && (second_out_o == 6'd0)),
    "error result carries completeness or seconds")
  `DTSV_ASSERT(a_ok_no_code,
    (out_valid_o && valid_res_o) |-> (error_code_o == dtsv_pkg::ERR_NONE),
    "valid result with error code")
  `DTSV_ASSERT_ALWAYS(a_reset_idle,
    !rst_ni |=> (!out_valid_o && !in_stall_o),
    "activity during reset")

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the date-time string validator one character per transaction.
// A scoreboard parses the same stream and queues the verdict due at each
// NUL. Every result is compared field by field, in order. Directed strings
// come first, then random ones, most of them date-times with random content.
// Both sides idle and stall in several phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import dtsv_pkg::*;

typedef enum logic [2:0] {
  FLD_YEAR   = 3'd0,
  FLD_MONTH  = 3'd1,
  FLD_DAY    = 3'd2,
  FLD_HOUR   = 3'd3,
  FLD_MINUTE = 3'd4,
  FLD_SECOND = 3'd5
} field_e;

class datetime_scoreboard;
  field_e       phase;
  logic [13:0]  acc;
  bit           sat, neg, pre, dig, sgn;
  dtsv_err_e    latched;
  logic [13:0]  year_q;
  logic [3:0]   month_q;
  logic [4:0]   day_q;
  logic [4:0]   hour_q;
  logic [5:0]   minute_q;
  dtsv_result_t expected_verdicts[$];
  int unsigned  mismatches;

  function new();
    mismatches = 0;
    clear_string();
  endfunction

  function void clear_field();
    acc = '0;
    sat = 0;
    neg = 0;
    pre = 0;
    dig = 0;
    sgn = 0;
  endfunction

  function void clear_string();
    phase    = FLD_YEAR;
    latched  = ERR_NONE;
    year_q   = '0;
    month_q  = '0;
    day_q    = '0;
    hour_q   = '0;
    minute_q = '0;
    clear_field();
  endfunction

  function void close_string(dtsv_err_e e, dtsv_cmp_e k, logic [5:0] sec);
    dtsv_result_t r;
    r.valid_res    = (e == ERR_NONE);
    r.error_code   = e;
    r.completeness = (e == ERR_NONE) ? k : CMP_FULL;
    r.year         = year_q;
    r.month        = month_q;
    r.day          = day_q;
    r.hour         = hour_q;
    r.minute       = minute_q;
    r.second       = (e == ERR_NONE) ? sec : 6'd0;
    expected_verdicts.push_back(r);
    clear_string();
  endfunction

  function void scan_char(logic [7:0] c);
    bit          is_dig, is_ws, is_sign, forced, bad, ends, delim_ok, leap;
    int unsigned v, lo, hi, nv;
    dtsv_err_e   err;
    dtsv_cmp_e   kind;
    is_dig   = (c >= CH_0 && c <= CH_9);
    is_ws    = (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
    is_sign  = (c == CH_PLUS || c == CH_MINUS);
    err      = ERR_NONE;
    kind     = CMP_FULL;
    ends     = 0;
    delim_ok = 0;
    if (latched != ERR_NONE) begin
      if (c == CH_NUL) close_string(latched, CMP_FULL, 6'd0);
      return;
    end
    if (is_dig) begin
      nv = acc * 10 + c - CH_0;
      if (sat || nv > ValMax) begin
        sat = 1;
        acc = ValMax;
      end else begin
        acc = 14'(nv);
      end
      dig = 1;
      return;
    end
    if (!dig && !sgn && is_ws) begin
      pre = 1;
      return;
    end
    if (!dig && !sgn && is_sign) begin
      sgn = 1;
      pre = 1;
      neg = (c == CH_MINUS);
      return;
    end
    forced = pre && !dig;
    bad    = sat || (neg && acc != 0);
    v      = forced ? 0 : acc;
    leap   = (year_q % 400 == 0) || (year_q % 4 == 0 && year_q % 100 != 0);
    lo     = 0;
    hi     = MinSecMax;
    case (phase)
      FLD_YEAR: hi = ValMax;
      FLD_MONTH: begin
        lo = 1;
        hi = MonthMax;
      end
      FLD_DAY: begin
        lo = 1;
        case (month_q)
          4'd4, 4'd6, 4'd9, 4'd11: hi = 30;
          4'd2: hi = leap ? 29 : 28;
          default: hi = 31;
        endcase
      end
      FLD_HOUR: hi = HourMax;
      default: hi = MinSecMax;
    endcase
    if (bad || v < lo || v > hi) begin
      err = dtsv_err_e'(phase + 1);
    end else if (forced) begin
      err = ERR_DELIM;
    end else begin
      case (phase)
        FLD_YEAR: begin
          year_q   = 14'(v);
          delim_ok = (c == CH_MINUS);
        end
        FLD_MONTH: begin
          month_q  = 4'(v);
          delim_ok = (c == CH_MINUS);
        end
        FLD_DAY: begin
          day_q    = 5'(v);
          delim_ok = (c == CH_SPACE || c == CH_NUL);
          ends     = (c == CH_NUL);
          kind     = CMP_DATE;
        end
        FLD_HOUR: begin
          hour_q   = 5'(v);
          delim_ok = (c == CH_COLON);
        end
        FLD_MINUTE: begin
          minute_q = 6'(v);
          delim_ok = (c == CH_COLON || c == CH_NUL);
          ends     = (c == CH_NUL);
          kind     = CMP_NO_SEC;
        end
        default: begin
          delim_ok = (c == CH_NUL);
          ends     = delim_ok;
        end
      endcase
      if (!delim_ok) err = ERR_DELIM;
    end
    if (err != ERR_NONE) begin
      if (c == CH_NUL) close_string(err, CMP_FULL, 6'd0);
      else latched = err;
    end else if (ends) begin
      close_string(ERR_NONE, kind, (phase == FLD_SECOND) ? 6'(v) : 6'd0);
    end else begin
      phase = field_e'(phase + 1);
      clear_field();
    end
  endfunction

  task report(string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task compare_field(string name, int unsigned got, int unsigned want);
    if (got != want) report($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  task check_verdict(dtsv_result_t got);
    dtsv_result_t want;
    if (expected_verdicts.size() == 0) begin
      report("result with no string pending");
      return;
    end
    want = expected_verdicts.pop_front();
    compare_field("valid_res", got.valid_res, want.valid_res);
    compare_field("error_code", got.error_code, want.error_code);
    compare_field("completeness", got.completeness, want.completeness);
    compare_field("year", got.year, want.year);
    compare_field("month", got.month, want.month);
    compare_field("day", got.day, want.day);
    compare_field("hour", got.hour, want.hour);
    compare_field("minute", got.minute, want.minute);
    compare_field("second", got.second, want.second);
  endtask
endclass

module tb;
  localparam int unsigned StuckLimit = 3000;
  localparam int unsigned HoldCycles = 400;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_in_i   = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        valid_res_o;
  logic [2:0]  error_code_o;
  logic [1:0]  completeness_o;
  logic [13:0] year_out_o;
  logic [3:0]  month_out_o;
  logic [4:0]  day_out_o;
  logic [4:0]  hour_out_o;
  logic [5:0]  minute_out_o;
  logic [5:0]  second_out_o;

  datetime_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          hold_go       = 0;
  int unsigned chars_sent    = 0;
  int unsigned stuck_cycles  = 0;
  logic [7:0]  char_line[$];
  int unsigned special_years[8] = '{0, 1900, 2000, 2023, 2024, 2100, 2400, 9999};

  datetime_string_validator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_in_i     (char_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .valid_res_o   (valid_res_o),
    .error_code_o  (error_code_o),
    .completeness_o(completeness_o),
    .year_out_o    (year_out_o),
    .month_out_o   (month_out_o),
    .day_out_o     (day_out_o),
    .hour_out_o    (hour_out_o),
    .minute_out_o  (minute_out_o),
    .second_out_o  (second_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_left = HoldCycles;
        hold_go   = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_verdict({valid_res_o, error_code_o, completeness_o, year_out_o,
                        month_out_o, day_out_o, hour_out_o, minute_out_o,
                        second_out_o});
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= StuckLimit) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, stuck_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_value(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(lo, hi);
    if (r < 86) return lo;
    if (r < 92) return hi;
    if (r < 96) return hi + 1;
    if (r < 98) return (lo == 0) ? 0 : lo - 1;
    return $urandom_range(10000, 99999);
  endfunction

  function automatic void put_field(int unsigned v);
    int unsigned r;
    string       digits;
    r = $urandom_range(0, 99);
    if (r < 3) return;
    if (r >= 80) begin
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 5) == 0) char_line.push_back(CH_SPACE);
        else char_line.push_back(8'(CH_TAB + $urandom_range(0, 4)));
      end
      if ($urandom_range(0, 1)) begin
        char_line.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      end
      if (r >= 96) return;
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) char_line.push_back(CH_0);
    end
    digits = $sformatf("%0d", v);
    foreach (digits[i]) char_line.push_back(digits[i]);
  endfunction

  function automatic void put_delim(logic [7:0] d);
    if ($urandom_range(0, 99) < 3) char_line.push_back(8'($urandom_range(1, 255)));
    else char_line.push_back(d);
  endfunction

  function automatic void make_line();
    int unsigned kind, stop;
    kind = $urandom_range(0, 99);
    char_line.delete();
    if (kind < 12) begin
      repeat ($urandom_range(0, 12)) char_line.push_back(8'($urandom_range(1, 255)));
    end else begin
      put_field(($urandom_range(0, 99) < 35) ? special_years[$urandom_range(0, 7)]
                                             : pick_value(0, 9999));
      put_delim(CH_MINUS);
      put_field(($urandom_range(0, 99) < 30) ? 2 : pick_value(1, 12));
      put_delim(CH_MINUS);
      put_field(($urandom_range(0, 99) < 35) ? $urandom_range(28, 31) : pick_value(1, 31));
      stop = $urandom_range(0, 9);
      if (stop >= 2) begin
        put_delim(CH_SPACE);
        put_field(pick_value(0, 23));
        put_delim(CH_COLON);
        put_field(pick_value(0, 59));
        if (stop >= 4) begin
          put_delim(CH_COLON);
          put_field(pick_value(0, 59));
        end
      end
      if (kind >= 88) begin
        char_line[$urandom_range(0, char_line.size() - 1)] = 8'($urandom_range(0, 255));
      end
      if (kind >= 95) begin
        repeat ($urandom_range(1, 4)) char_line.push_back(8'($urandom_range(1, 255)));
      end
    end
    char_line.push_back(CH_NUL);
  endfunction

  task send_char(logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
    sb.scan_char(c);
    chars_sent++;
  endtask

  task send_text(string s);
    foreach (s[i]) send_char(s[i]);
    send_char(CH_NUL);
  endtask

  task drain();
    in_valid_i <= 1'b0;
    while (sb.expected_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task run_phase(int unsigned idle, int unsigned stall, int unsigned count, bit hold);
    int unsigned target;
    send_idle_pct = idle;
    stall_pct     = stall;
    target        = chars_sent + count;
    if (hold) hold_go = 1;
    while (chars_sent < target) begin
      make_line();
      foreach (char_line[i]) send_char(char_line[i]);
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_text("");
    send_text("\377");
    send_text("0-1-1");
    send_text("9999-12-31 23:59:59");
    drain();
    run_phase(0, 0, 430, 1);
    run_phase(79, 0, 430, 0);
    run_phase(0, 79, 430, 0);
    run_phase(14, 14, 430, 0);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_verdicts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
